// File: rtl/core/vfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_pkg: shared types for the video fragment reassembler
// Command and status codes, the store access control and the result record
// passed from the control unit to the output pipeline.
// ----------------------------------------------------------------------------
package vfr_pkg;

	// fixed field widths
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned IDX_W   = 14;
	localparam int unsigned ADDR_W  = 8;
	localparam int unsigned LEN_W   = 11;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned OFF_W   = 16;
	localparam int unsigned RSIZE_W = 17;

	// bit positions inside the fragment word
	localparam int unsigned ID_BIT  = 14;
	localparam int unsigned EOF_BIT = 15;

	typedef enum logic [1:0] {
		CMD_HEADER  = 2'd0,
		CMD_BYTE    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_ACCEPT  = 4'd0,
		ST_BUSY    = 4'd1,
		ST_SEQ     = 4'd2,
		ST_STORED  = 4'd3,
		ST_SKIP    = 4'd4,
		ST_OVER    = 4'd5,
		ST_DONE    = 4'd6,
		ST_RELEASE = 4'd7,
		ST_READ    = 4'd8
	} status_t;

	// store access strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// one result item before the read byte is merged in
	typedef struct packed {
		status_t              status;
		logic                 frame_ready;
		logic                 ready_bank;
		logic                 ready_frame_id;
		logic [RSIZE_W-1:0]   ready_size;
		logic [ADDR_W-1:0]    ready_address;
		logic                 rd_hit;
	} result_t;

endpackage

// File: rtl/core/video_fragment_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_fragment_reassembler: two-bank video frame reassembly
// Stream in of headers, payload bytes, release and read commands; one status
// transfer out for every command.
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one command per transfer, its kind in tuser; m_axis
//   returns exactly one result per command, in order, kind of result in tuser.
// - Throughput is one command per cycle while m_axis is not stalled, set by
//   the control update and one store access (write or read) per cycle.
// - A result is registered twice on its way out: in the decision stage,
//   together with the store read, and then in the output register.
// - A read returns the byte of the frame store at bank and offset; a byte
//   never written reads as whatever the memory holds.
// - While the output is stalled the block keeps taking commands until the
//   decision stage and the output register are both full, then drops
//   s_axis_tready; no result is lost or reordered.
// - Reset clears all sequencing state, the bank sizes and the held flag; the
//   frame store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module video_fragment_reassembler
	import vfr_pkg::*;
#(
	parameter int unsigned BANK_BYTES         = 65536,
	parameter int unsigned MAX_FRAGMENT_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// fragment_word[15:0], source_address[23:16], payload_length[34:24],
	// data_byte[42:35], read_bank[43], read_offset[59:44], zero[63:60]
	input  logic [63:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_ready[0], ready_bank[1], ready_frame_id[2], ready_size[19:3],
	// ready_address[27:20], read_data[35:28], zero[39:36]
	output logic [39:0] m_axis_tdata,
	// status[3:0]
	output logic [3:0]  m_axis_tuser
);

	localparam int unsigned SIZE_W  = $clog2(BANK_BYTES + 1);
	localparam int unsigned BANK_AW = $clog2(BANK_BYTES);

	logic                accept;
	logic                out_free;
	logic                advance;
	result_t             result;
	mem_ctl_t            mem_ctl;
	logic [BANK_AW:0]    mem_addr;
	logic [BYTE_W-1:0]   mem_wdata;
	logic [BYTE_W-1:0]   mem_rdata;

	logic                valid_s1;
	result_t             result_s1;
	logic                m_valid_q;
	logic [39:0]         m_data_q;
	logic [3:0]          m_user_q;
	logic [BYTE_W-1:0]   read_data;

	// handshake: decision stage advances when the output register is free
	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	vfr_ctrl #(
		.BANK_BYTES         (BANK_BYTES),
		.MAX_FRAGMENT_BYTES (MAX_FRAGMENT_BYTES),
		.SIZE_W             (SIZE_W),
		.BANK_AW            (BANK_AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.command        (cmd_t'(s_axis_tuser)),
		.fragment_word  (s_axis_tdata[15:0]),
		.source_address (s_axis_tdata[23:16]),
		.payload_length (s_axis_tdata[34:24]),
		.data_byte      (s_axis_tdata[42:35]),
		.read_bank      (s_axis_tdata[43]),
		.read_offset    (s_axis_tdata[59:44]),
		.result         (result),
		.mem_ctl        (mem_ctl),
		.mem_addr       (mem_addr),
		.mem_wdata      (mem_wdata)
	);

	// store strobes only for accepted transfers
	mem_ctl_t mem_ctl_acc;
	assign mem_ctl_acc.wr_en = mem_ctl.wr_en & accept;
	assign mem_ctl_acc.rd_en = mem_ctl.rd_en & accept;

	vfr_store #(
		.MEM_AW (BANK_AW + 1)
	) u_store (
		.clk       (clk),
		.mem_ctl   (mem_ctl_acc),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	// decision stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
		end
	end

	// read byte joins the result as it leaves the decision stage
	assign read_data = result_s1.rd_hit ? mem_rdata : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_user_q <= result_s1.status;
			m_data_q <= {4'b0, read_data, result_s1.ready_address, result_s1.ready_size,
				result_s1.ready_frame_id, result_s1.ready_bank, result_s1.frame_ready};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// File: rtl/core/vfr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_store: two-bank frame byte store
// Single-port synchronous memory, one access per cycle, registered read data
// that holds until the next read.
// ----------------------------------------------------------------------------
module vfr_store
	import vfr_pkg::*;
#(
	parameter int unsigned MEM_AW = 17
) (
	input  logic              clk,
	input  mem_ctl_t          mem_ctl,
	input  logic [MEM_AW-1:0] mem_addr,
	input  logic [BYTE_W-1:0] mem_wdata,
	output logic [BYTE_W-1:0] mem_rdata
);

	logic [BYTE_W-1:0] store_mem [2**MEM_AW];
	logic [BYTE_W-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			store_mem[mem_addr] <= mem_wdata;
		end
		if (mem_ctl.rd_en) begin
			rdata_q <= store_mem[mem_addr];
		end
	end

	assign mem_rdata = rdata_q;

endmodule

// File: rtl/core/vfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_ctrl: fragment sequencing and bank control
// Holds the reassembly state, decides each transfer's status combinationally
// and issues the store write or read for it.
// ----------------------------------------------------------------------------
module vfr_ctrl
	import vfr_pkg::*;
#(
	parameter int unsigned BANK_BYTES         = 65536,
	parameter int unsigned MAX_FRAGMENT_BYTES = 1024,
	parameter int unsigned SIZE_W             = 17,
	parameter int unsigned BANK_AW            = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  cmd_t                 command,
	input  logic [WORD_W-1:0]    fragment_word,
	input  logic [ADDR_W-1:0]    source_address,
	input  logic [LEN_W-1:0]     payload_length,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 read_bank,
	input  logic [OFF_W-1:0]     read_offset,
	output result_t              result,
	output mem_ctl_t             mem_ctl,
	output logic [BANK_AW:0]     mem_addr,
	output logic [BYTE_W-1:0]    mem_wdata
);

	localparam int unsigned LEN_CAP = (MAX_FRAGMENT_BYTES > 2047) ? 2047 : MAX_FRAGMENT_BYTES;
	localparam logic [LEN_W-1:0]       MAX_LEN  = LEN_W'(LEN_CAP);
	localparam logic [SIZE_W-1:0]      BANK_LIM = SIZE_W'(BANK_BYTES);
	localparam logic [SIZE_W+OFF_W-1:0] OFF_LIM = (SIZE_W + OFF_W)'(BANK_BYTES);

	// state registers
	logic               fill_q, fill_n;
	logic               liv_q, liv_n;
	logic [IDX_W-1:0]   lidx_q, lidx_n;
	logic               lidv_q, lidv_n;
	logic               lid_q, lid_n;
	logic [SIZE_W-1:0]  cur_size_q, cur_size_n;
	logic [SIZE_W-1:0]  held_size_q, held_size_n;
	logic [ADDR_W-1:0]  cur_addr_q, cur_addr_n;
	logic [ADDR_W-1:0]  held_addr_q, held_addr_n;
	logic               held_q, held_n;
	logic               held_bank_q, held_bank_n;
	logic               held_id_q, held_id_n;
	logic [LEN_W-1:0]   left_q, left_n;
	logic               storing_q, storing_n;
	logic               endp_q, endp_n;

	status_t            status;
	logic               rd_hit;
	logic [SIZE_W+OFF_W-1:0] off_wide;
	logic [SIZE_W+RSIZE_W-1:0] size_wide;

	assign off_wide = {{SIZE_W{1'b0}}, read_offset};

	// next-state and status decision for the accepted transfer
	always_comb begin
		logic [IDX_W-1:0] idx;
		logic             frag_id;
		logic             frag_eof;
		logic [LEN_W-1:0] len;
		logic [IDX_W:0]   exp_idx;
		logic             do_complete;

		fill_n      = fill_q;
		liv_n       = liv_q;
		lidx_n      = lidx_q;
		lidv_n      = lidv_q;
		lid_n       = lid_q;
		cur_size_n  = cur_size_q;
		held_size_n = held_size_q;
		cur_addr_n  = cur_addr_q;
		held_addr_n = held_addr_q;
		held_n      = held_q;
		held_bank_n = held_bank_q;
		held_id_n   = held_id_q;
		left_n      = left_q;
		storing_n   = storing_q;
		endp_n      = endp_q;
		status      = ST_READ;
		rd_hit      = 1'b0;
		mem_ctl     = '0;
		mem_addr    = {fill_q, cur_size_q[BANK_AW-1:0]};
		mem_wdata   = data_byte;
		do_complete = 1'b0;

		idx      = fragment_word[IDX_W-1:0];
		frag_id  = fragment_word[ID_BIT];
		frag_eof = fragment_word[EOF_BIT];
		len      = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
		exp_idx  = '0;

		unique case (command)
			CMD_HEADER: begin
				if (held_q) begin
					status = ST_BUSY;
				end else begin
					endp_n = 1'b0;
					// restart on zero word or a new frame id
					if (fragment_word == '0 || !lidv_q || lid_q != frag_id) begin
						liv_n      = 1'b0;
						cur_size_n = '0;
					end
					exp_idx = liv_n ? ({1'b0, lidx_q} + 1'b1) : '0;
					if ({1'b0, idx} != exp_idx) begin
						liv_n      = 1'b0;
						cur_size_n = '0;
						left_n     = len;
						storing_n  = 1'b0;
						status     = ST_SEQ;
					end else begin
						lidx_n     = idx;
						liv_n      = 1'b1;
						lid_n      = frag_id;
						lidv_n     = 1'b1;
						cur_addr_n = source_address;
						left_n     = len;
						storing_n  = 1'b1;
						endp_n     = frag_eof;
						status     = ST_ACCEPT;
						// empty fragment
						if (len == '0) begin
							storing_n = 1'b0;
							if (frag_eof) begin
								do_complete = 1'b1;
								status      = ST_DONE;
							end
						end
					end
				end
			end
			CMD_BYTE: begin
				if (left_q == '0) begin
					status = ST_SKIP;
				end else begin
					left_n = left_q - 1'b1;
					if (!storing_q) begin
						status = ST_SKIP;
					end else if (cur_size_q < BANK_LIM) begin
						mem_ctl.wr_en = 1'b1;
						cur_size_n    = cur_size_q + 1'b1;
						status        = ST_STORED;
					end else begin
						status = ST_OVER;
					end
					// last byte of an accepted fragment
					if (left_n == '0 && storing_q) begin
						storing_n = 1'b0;
						if (endp_q) begin
							do_complete = 1'b1;
							status      = ST_DONE;
						end
					end
				end
			end
			CMD_RELEASE: begin
				held_n = 1'b0;
				status = ST_RELEASE;
			end
			CMD_READ: begin
				mem_ctl.rd_en = 1'b1;
				mem_addr      = {read_bank, off_wide[BANK_AW-1:0]};
				rd_hit        = (off_wide < OFF_LIM);
				status        = ST_READ;
			end
			default: begin
				status = ST_READ;
			end
		endcase

		// frame completion: hold the bank and swap to the other one
		if (do_complete) begin
			held_n      = 1'b1;
			held_bank_n = fill_q;
			held_id_n   = lid_n;
			held_size_n = cur_size_n;
			held_addr_n = cur_addr_n;
			liv_n       = 1'b0;
			fill_n      = ~fill_q;
			cur_size_n  = '0;
			endp_n      = 1'b0;
			storing_n   = 1'b0;
			left_n      = '0;
		end
	end

	// result fields after the update
	assign size_wide = {{RSIZE_W{1'b0}}, held_size_n};

	always_comb begin
		result                = '0;
		result.status         = status;
		result.frame_ready    = held_n;
		result.ready_bank     = held_n & held_bank_n;
		result.ready_frame_id = held_n & held_id_n;
		result.ready_size     = held_n ? size_wide[RSIZE_W-1:0] : '0;
		result.ready_address  = held_n ? held_addr_n : '0;
		result.rd_hit         = rd_hit;
	end

	// state update on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 1'b0;
			liv_q       <= 1'b0;
			lidx_q      <= '0;
			lidv_q      <= 1'b0;
			lid_q       <= 1'b0;
			cur_size_q  <= '0;
			held_size_q <= '0;
			cur_addr_q  <= '0;
			held_addr_q <= '0;
			held_q      <= 1'b0;
			held_bank_q <= 1'b0;
			held_id_q   <= 1'b0;
			left_q      <= '0;
			storing_q   <= 1'b0;
			endp_q      <= 1'b0;
		end else if (accept) begin
			fill_q      <= fill_n;
			liv_q       <= liv_n;
			lidx_q      <= lidx_n;
			lidv_q      <= lidv_n;
			lid_q       <= lid_n;
			cur_size_q  <= cur_size_n;
			held_size_q <= held_size_n;
			cur_addr_q  <= cur_addr_n;
			held_addr_q <= held_addr_n;
			held_q      <= held_n;
			held_bank_q <= held_bank_n;
			held_id_q   <= held_id_n;
			left_q      <= left_n;
			storing_q   <= storing_n;
			endp_q      <= endp_n;
		end
	end

endmodule

// File: tb/video_fragment_reassembler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_fragment_reassembler_test: self-checking bench for the reassembler
// Drives headers, payload bytes, release and read commands on s_axis and
// predicts each status transfer on m_axis from a bit-level copy of the bank
// store and sequencing state. Covers directed corner cases, output
// back-pressure and a long random mix of well-formed frames, broken frames
// and noise, part of it at full rate on both sides.
// ----------------------------------------------------------------------------
module video_fragment_reassembler_test;
	import vfr_pkg::*;

	localparam int unsigned BANK_BYTES   = 65536;
	localparam int unsigned MAX_FRAG     = 1024;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned PAUSE_CYCLES = 300;

	// one command as offered on s_axis
	typedef struct {
		cmd_t        cmd;
		logic [15:0] word;
		logic [7:0]  addr;
		logic [10:0] len;
		logic [7:0]  data;
		logic        bank;
		logic [15:0] off;
	} cmd_item_t;

	// one status transfer as expected on m_axis
	typedef struct {
		status_t            status;
		logic               frame_ready;
		logic               ready_bank;
		logic               ready_frame_id;
		logic [RSIZE_W-1:0] ready_size;
		logic [7:0]         ready_address;
		logic [7:0]         read_data;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	// predicted reassembly state
	logic        fill_sel = 1'b0;
	logic        seq_valid = 1'b0;
	logic [13:0] seq_index = '0;
	logic        id_seen = 1'b0;
	logic        seq_id = 1'b0;
	int unsigned bank_count [2] = '{0, 0};
	logic [7:0]  bank_tag [2] = '{8'h00, 8'h00};
	int unsigned written_len [2] = '{0, 0};
	logic [7:0]  frame_copy [0:2*BANK_BYTES-1];
	logic        hold_valid = 1'b0;
	logic        hold_bank = 1'b0;
	logic        hold_id = 1'b0;
	int unsigned bytes_due = 0;
	logic        keep_bytes = 1'b0;
	logic        end_armed = 1'b0;

	frame_result_t result_due [$];
	frame_result_t next_result;
	int unsigned   fail_count = 0;
	int unsigned   sent_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   rx_hold_len = 0;
	int unsigned   rx_hold_count = 0;
	logic          steady_flow = 1'b0;

	video_fragment_reassembler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// run length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("video_fragment_reassembler_test: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, long hold-offs on request
	always @(negedge clk) begin
		if (rx_hold_len != 0) begin
			rx_hold_count = rx_hold_len;
			rx_hold_len = 0;
		end
		if (rx_hold_count != 0) begin
			rx_hold_count--;
			m_axis_tready <= 1'b0;
		end else if (steady_flow) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 13);
		end
	end

	// close the frame being filled and swap banks
	function void hold_frame();
		hold_valid = 1'b1;
		hold_bank = fill_sel;
		hold_id = seq_id;
		seq_valid = 1'b0;
		fill_sel = ~fill_sel;
		bank_count[fill_sel] = 0;
		end_armed = 1'b0;
		keep_bytes = 1'b0;
		bytes_due = 0;
	endfunction

	// advance the predicted state by one command and queue its status
	task automatic apply_command(input cmd_item_t it);
		frame_result_t r;
		status_t       st;
		logic [13:0]   idx;
		logic          fid;
		int unsigned   want;
		int unsigned   slot;
		logic [7:0]    rd;
		rd = 8'h00;
		case (it.cmd)
			CMD_HEADER: begin
				if (hold_valid) begin
					st = ST_BUSY;
				end else begin
					idx = it.word[IDX_W-1:0];
					fid = it.word[ID_BIT];
					end_armed = 1'b0;
					// restart on a zero word or a new frame id
					if (it.word == 16'h0000 || !id_seen || seq_id != fid) begin
						seq_valid = 1'b0;
						bank_count[fill_sel] = 0;
					end
					want = seq_valid ? int'(seq_index) + 1 : 0;
					bytes_due = (it.len > MAX_FRAG) ? MAX_FRAG : it.len;
					if (int'(idx) != want) begin
						seq_valid = 1'b0;
						bank_count[fill_sel] = 0;
						keep_bytes = 1'b0;
						st = ST_SEQ;
					end else begin
						seq_index = idx;
						seq_valid = 1'b1;
						seq_id = fid;
						id_seen = 1'b1;
						bank_tag[fill_sel] = it.addr;
						keep_bytes = 1'b1;
						end_armed = it.word[EOF_BIT];
						st = ST_ACCEPT;
						// empty fragment: may end the frame at once
						if (bytes_due == 0) begin
							keep_bytes = 1'b0;
							if (end_armed) begin
								hold_frame();
								st = ST_DONE;
							end
						end
					end
				end
			end
			CMD_BYTE: begin
				if (bytes_due == 0) begin
					st = ST_SKIP;
				end else begin
					bytes_due--;
					if (!keep_bytes) begin
						st = ST_SKIP;
					end else if (bank_count[fill_sel] < BANK_BYTES) begin
						slot = (fill_sel ? BANK_BYTES : 0) + bank_count[fill_sel];
						frame_copy[slot] = it.data;
						bank_count[fill_sel]++;
						if (bank_count[fill_sel] > written_len[fill_sel])
							written_len[fill_sel] = bank_count[fill_sel];
						st = ST_STORED;
					end else begin
						st = ST_OVER;
					end
					// last byte of an accepted fragment
					if (bytes_due == 0 && keep_bytes) begin
						keep_bytes = 1'b0;
						if (end_armed) begin
							hold_frame();
							st = ST_DONE;
						end
					end
				end
			end
			CMD_RELEASE: begin
				hold_valid = 1'b0;
				st = ST_RELEASE;
			end
			default: begin
				rd = frame_copy[(it.bank ? BANK_BYTES : 0) + it.off];
				st = ST_READ;
			end
		endcase
		r.status = st;
		r.frame_ready = hold_valid;
		r.ready_bank = hold_valid ? hold_bank : 1'b0;
		r.ready_frame_id = hold_valid ? hold_id : 1'b0;
		r.ready_size = hold_valid ? RSIZE_W'(bank_count[hold_bank]) : '0;
		r.ready_address = hold_valid ? bank_tag[hold_bank] : 8'h00;
		r.read_data = rd;
		result_due.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %0h",
					$time, m_axis_tuser);
				fail_count++;
			end else begin
				next_result = result_due.pop_front();
				compare_field("status", 32'(next_result.status), 32'(m_axis_tuser));
				compare_field("frame_ready", 32'(next_result.frame_ready),
					32'(m_axis_tdata[0]));
				compare_field("ready_bank", 32'(next_result.ready_bank),
					32'(m_axis_tdata[1]));
				compare_field("ready_frame_id", 32'(next_result.ready_frame_id),
					32'(m_axis_tdata[2]));
				compare_field("ready_size", 32'(next_result.ready_size),
					32'(m_axis_tdata[19:3]));
				compare_field("ready_address", 32'(next_result.ready_address),
					32'(m_axis_tdata[27:20]));
				compare_field("read_data", 32'(next_result.read_data),
					32'(m_axis_tdata[35:28]));
			end
		end
	end

	// every field random, command included
	function automatic cmd_item_t noise_item();
		cmd_item_t it;
		it.cmd = cmd_t'(2'($urandom_range(0, 3)));
		it.word = 16'($urandom_range(0, 16'hFFFF));
		it.addr = 8'($urandom_range(0, 8'hFF));
		it.len = 11'($urandom_range(0, 11'h7FF));
		it.data = 8'($urandom_range(0, 8'hFF));
		it.bank = 1'($urandom_range(0, 1));
		it.off = 16'($urandom_range(0, 16'hFFFF));
		return it;
	endfunction

	// offer one command and wait for its transfer
	task automatic send_item(input cmd_item_t it);
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.cmd;
		s_axis_tdata <= {4'b0000, it.off, it.bank, it.data, it.len, it.addr, it.word};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		apply_command(it);
		sent_count++;
	endtask

	task automatic send_header(input logic [15:0] word, input logic [7:0] addr,
			input logic [10:0] len);
		cmd_item_t it;
		it = noise_item();
		it.cmd = CMD_HEADER;
		it.word = word;
		it.addr = addr;
		it.len = len;
		send_item(it);
	endtask

	task automatic send_byte(input logic [7:0] data);
		cmd_item_t it;
		it = noise_item();
		it.cmd = CMD_BYTE;
		it.data = data;
		send_item(it);
	endtask

	task automatic send_release();
		cmd_item_t it;
		it = noise_item();
		it.cmd = CMD_RELEASE;
		send_item(it);
	endtask

	task automatic send_read(input logic bank, input logic [15:0] off);
		cmd_item_t it;
		it = noise_item();
		it.cmd = CMD_READ;
		it.bank = bank;
		it.off = off;
		send_item(it);
	endtask

	// read a byte that has been written, else free the held frame
	task automatic send_stored_read();
		logic b;
		b = 1'($urandom_range(0, 1));
		if (written_len[b] == 0)
			b = ~b;
		if (written_len[b] == 0)
			send_release();
		else
			send_read(b, 16'($urandom_range(0, written_len[b] - 1)));
	endtask

	// stop offering and let every expected result arrive
	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (result_due.size() != 0) @(posedge clk);
	endtask

	// corner cases of every command
	task automatic test_directed();
		send_release();
		send_byte(8'hFF);
		send_header(16'h0000, 8'hFF, 11'd3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		// empty end fragment completes the frame
		send_header(16'h8001, 8'h00, 11'd0);
		send_header(16'hFFFF, 8'hFF, 11'h7FF);
		send_read(1'b0, 16'h0000);
		send_read(1'b0, 16'h0002);
		send_release();
		// saturated length, then a header mid-payload
		send_header(16'h4000, 8'h5A, 11'h7FF);
		send_byte(8'h12);
		send_byte(8'h34);
		send_header(16'hC001, 8'h5A, 11'd2);
		send_byte(8'h56);
		send_byte(8'h78);
		send_release();
		// out-of-sequence index, its bytes and a stray byte
		send_header(16'h4005, 8'h33, 11'd2);
		send_byte(8'h9A);
		send_byte(8'hBC);
		send_byte(8'hDE);
		send_read(1'b1, 16'h0003);
		send_header(16'hC000, 8'hC3, 11'd0);
		send_release();
		wait_for_results();
	endtask

	// long receiver hold-off while commands keep coming
	task automatic test_backpressure();
		int n;
		rx_hold_len = PAUSE_CYCLES;
		send_header({1'b0, ~seq_id, 14'd0}, 8'h81, 11'd24);
		for (n = 0; n < 24; n++)
			send_byte(8'($urandom_range(0, 255)));
		send_stored_read();
		send_release();
		wait_for_results();
	endtask

	// mostly well-formed frames with random content, the rest noise
	task automatic test_random_traffic();
		int unsigned first;
		int          f;
		int          n;
		int          nfrag;
		int          nbytes;
		int          flaw;
		logic        fid;
		logic [13:0] start_idx;
		logic [7:0]  tag;
		logic [10:0] len;
		cmd_item_t   it;
		first = sent_count;
		while (sent_count - first < RANDOM_ITEMS) begin
			// first quarter at full rate on both sides
			steady_flow = (sent_count - first < RANDOM_ITEMS / 4);
			if ($urandom_range(0, 99) < 60) begin
				if (hold_valid)
					send_release();
				fid = 1'($urandom_range(0, 1));
				// continue the current index run when the id matches
				if (seq_valid && fid == seq_id && seq_index != 14'h3FFF)
					start_idx = seq_index + 14'd1;
				else
					start_idx = 14'd0;
				nfrag = $urandom_range(1, 4);
				tag = 8'($urandom_range(0, 255));
				for (f = 0; f < nfrag; f++) begin
					flaw = $urandom_range(0, 99);
					len = ($urandom_range(0, 99) < 3) ? 11'($urandom_range(1025, 2047)) :
						11'($urandom_range(0, 12));
					send_header({f == nfrag - 1, fid,
						start_idx + 14'(f) + ((flaw < 5) ? 14'd1 : 14'd0)}, tag, len);
					nbytes = int'(len);
					if (len > MAX_FRAG)
						nbytes = int'($urandom_range(0, 4));
					else if (flaw >= 5 && flaw < 11 && nbytes > 0)
						nbytes = int'($urandom_range(0, nbytes - 1));
					else if (flaw >= 11 && flaw < 16)
						nbytes += int'($urandom_range(1, 2));
					for (n = 0; n < nbytes; n++)
						send_byte(8'($urandom_range(0, 255)));
				end
				repeat ($urandom_range(0, 3)) send_stored_read();
				if ($urandom_range(0, 99) < 30)
					send_header(16'($urandom_range(0, 16'hFFFF)),
						8'($urandom_range(0, 255)), 11'($urandom_range(0, 11'h7FF)));
				if ($urandom_range(0, 99) < 85)
					send_release();
			end else begin
				it = noise_item();
				if (it.cmd == CMD_READ)
					send_stored_read();
				else
					send_item(it);
			end
		end
		steady_flow = 1'b0;
		wait_for_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random_traffic();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("video_fragment_reassembler_test: PASS");
		else
			$display("video_fragment_reassembler_test: FAIL");
		$finish;
	end

endmodule
